>>> rtl/abk_pkg.sv
`timescale 1ns / 1ps
package abk_pkg;

  localparam int FRAC   = 24;
  localparam int CFG_W  = 31;
  localparam int MW     = 36;
  localparam int PW     = 2 * MW;
  localparam int RW     = PW - FRAC;
  localparam int SW     = 50;
  localparam int QW     = 33;
  localparam int NUM_W  = 58;
  localparam int DEN_W  = 34;

  localparam logic signed [31:0] ONE_P = 32'sh0100_0000;
  localparam logic [CFG_W-1:0] ANGLE_NOISE_RST = 31'd16777;
  localparam logic [CFG_W-1:0] BIAS_NOISE_RST  = 31'd50332;
  localparam logic [CFG_W-1:0] MEAS_NOISE_RST  = 31'd503316;

  typedef enum logic [1:0] {
    CFG_ANGLE_NOISE = 2'd0,
    CFG_BIAS_NOISE  = 2'd1,
    CFG_MEAS_NOISE  = 2'd2
  } cfg_idx_t;

  typedef struct packed {
    logic signed [31:0] measured_angle;
    logic signed [31:0] measured_rate;
    logic [23:0]        time_step;
  } in_word_t;

  typedef struct packed {
    logic signed [31:0] angle_estimate_out;
    logic signed [31:0] bias_estimate_out;
    logic signed [31:0] unbiased_rate;
    logic               fault_flag;
  } out_word_t;

  typedef enum logic [4:0] {
    OP_IDLE, OP_RATE, OP_M1, OP_M2, OP_M3, OP_M4, OP_M5, OP_M6, OP_Y,
    OP_DIV0, OP_WAIT0, OP_DIV1, OP_WAIT1,
    OP_U1, OP_U2, OP_U3, OP_U4, OP_U5, OP_U6, OP_U7, OP_DONE
  } op_t;

  typedef struct packed {
    logic load;
    logic out_load;
    logic div_start;
    op_t  op;
  } cmd_t;

  typedef struct packed {
    logic s_zero;
    logic div_done;
  } stat_t;

  // True when a wide sum does not fit a 32-bit signed word.
  function automatic logic ovf32(input logic signed [SW-1:0] v);
    return !((&v[SW-1:31]) || (~|v[SW-1:31]));
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [SW-1:0] v);
    logic o;
    o = ovf32(v);
    if (o) begin
      return v[SW-1] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    end
    return v[31:0];
  endfunction

  // Drops the fraction bits, rounding to nearest with ties away from zero.
  function automatic logic signed [RW-1:0] rnd(input logic signed [PW-1:0] p);
    logic [PW-1:0] t;
    t = p + (PW'(1) << (FRAC - 1)) - PW'(p[PW-1]);
    return t[PW-1:FRAC];
  endfunction

endpackage

>>> rtl/abk_if.sv
`timescale 1ns / 1ps
interface abk_in_if;
  import abk_pkg::*;
  logic     valid;
  logic     ready;
  in_word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface abk_out_if;
  import abk_pkg::*;
  logic      valid;
  logic      ready;
  out_word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

>>> rtl/angle_bias_kalman_filter.sv
`timescale 1ns / 1ps
// Two-state angle and gyro-bias Kalman filter for one axis.
// Input channel in_ch carries one word per sensor sample: the accelerometer
// angle, the gyro rate and the time step. Output channel out_ch carries one
// word per input word: the updated angle, the updated bias, the gyro rate
// less the previous bias, and a fault bit for saturation or zero variance.
// Noise terms are written through cfg_we, cfg_index and cfg_data while the
// block is idle; writes to an index past the last register are dropped.
// Words are processed one at a time. An accepted word reaches the output
// register after the two divisions of the gain calculation through the
// shared restoring divider; when the innovation variance is zero the
// divisions are skipped. A new word is accepted only once the previous one
// has been loaded into the output register.
// The shared 36x36 multiplier handles the rest, one product per cycle.
// Reset clears the estimates to zero, the covariance to identity and the
// noise registers to their defaults. If the receiver stalls, the finished
// word waits in the output register; the next word may be accepted and
// computed meanwhile, and holds in its final step until the register frees.
module angle_bias_kalman_filter (
  input  logic                      clk,
  input  logic                      rst,
  abk_in_if.sink                    in_ch,
  abk_out_if.source                 out_ch,
  input  logic                      cfg_we,
  input  logic [1:0]                cfg_index,
  input  logic [abk_pkg::CFG_W-1:0] cfg_data
);
  import abk_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  // Sequencer: owns the handshakes and steps the datapath.
  abk_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // Filter state, noise registers, multiplier and divider.
  abk_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .in_word   (in_ch.data),
    .out_word  (out_ch.data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

endmodule

>>> rtl/abk_div.sv
`timescale 1ns / 1ps
module abk_div (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  logic [31:0]            p_mag,
  input  logic [32:0]            s_mag,
  output logic                   done,
  output logic [abk_pkg::QW-1:0] q,
  output logic                   ovf
);
  import abk_pkg::*;

  // Restoring division of (2n + d) by 2d, one quotient bit per cycle.
  logic [NUM_W-1:0]    rem;
  logic [DEN_W+31:0]   dsh;
  logic [5:0]          cnt;
  logic                busy;
  logic [NUM_W-1:0]    num;
  logic [DEN_W-1:0]    den;
  logic                fits;

  assign num  = {p_mag, 25'd0} + NUM_W'(s_mag);
  assign den  = {s_mag, 1'b0};
  assign fits = (DEN_W + 32)'(rem) >= dsh;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= busy && (cnt == 6'd0);
      if (start) begin
        busy <= 1'b1;
        cnt  <= 6'd32;
        rem  <= num;
        dsh  <= {den, 32'd0};
        ovf  <= {9'd0, num} >= {den, 33'd0};
      end else if (busy) begin
        if (fits) begin
          rem <= rem - NUM_W'(dsh);
        end
        q   <= {q[QW-2:0], fits};
        dsh <= dsh >> 1;
        cnt <= cnt - 6'd1;
        if (cnt == 6'd0) begin
          busy <= 1'b0;
        end
      end
    end
  end

endmodule

>>> rtl/abk_datapath.sv
`timescale 1ns / 1ps
module abk_datapath (
  input  logic                     clk,
  input  logic                     rst,
  input  abk_pkg::cmd_t            cmd,
  output abk_pkg::stat_t           stat,
  input  abk_pkg::in_word_t        in_word,
  output abk_pkg::out_word_t       out_word,
  input  logic                     cfg_we,
  input  logic [1:0]               cfg_index,
  input  logic [abk_pkg::CFG_W-1:0] cfg_data
);
  import abk_pkg::*;

  logic [CFG_W-1:0] apn, bpn, mn;
  logic signed [31:0] angle, bias, c0, c1, c2, c3;
  logic fault;
  in_word_t in_q;
  logic signed [31:0] rate, y, k0, k1, p00, p01;
  logic signed [32:0] d;
  logic signed [MW-1:0] t;
  logic signed [DEN_W-1:0] s;
  logic signed [MW-1:0] ma, mb;
  logic signed [PW-1:0] prod;
  logic signed [RW-1:0] r;
  logic signed [MW-1:0] dtx;

  logic signed [SW-1:0] rate_sum, ang_sum, c3_sum, c3_sub, c1_d, c2_d, c0_sum;
  logic signed [SW-1:0] y_sum, bias_sum, c0_sub, c1_sub, c2_sub;

  logic signed [31:0] dp;
  logic [32:0] pa;
  logic [DEN_W-1:0] sa;
  logic div_done, div_ovf, div_neg;
  logic [QW-1:0] div_q;
  logic [33:0] qm;
  logic signed [MW-1:0] gv;
  logic signed [SW-1:0] gsum;

  assign dtx = $signed({12'd0, in_q.time_step});
  assign r   = rnd(prod);

  always_comb begin
    ma = '0;
    mb = '0;
    case (cmd.op)
      OP_M1: begin ma = dtx; mb = MW'(rate); end
      OP_M2: begin ma = dtx; mb = MW'(c3); end
      OP_M3: begin ma = dtx; mb = $signed({5'd0, bpn}); end
      OP_M5: begin ma = dtx; mb = t; end
      OP_U1: begin ma = MW'(k0); mb = MW'(y); end
      OP_U2: begin ma = MW'(k1); mb = MW'(y); end
      OP_U3: begin ma = MW'(k0); mb = MW'(p00); end
      OP_U4: begin ma = MW'(k0); mb = MW'(p01); end
      OP_U5: begin ma = MW'(k1); mb = MW'(p00); end
      OP_U6: begin ma = MW'(k1); mb = MW'(p01); end
      default: begin ma = '0; mb = '0; end
    endcase
  end

  assign rate_sum = SW'(in_q.measured_rate) - SW'(bias);
  assign ang_sum  = SW'(angle) + SW'(r);
  assign c3_sum   = SW'(c3) + SW'(r);
  assign c3_sub   = SW'(c3) - SW'(r);
  assign c1_d     = SW'(c1) - SW'(d);
  assign c2_d     = SW'(c2) - SW'(d);
  assign c0_sum   = SW'(c0) + SW'(r);
  assign c0_sub   = SW'(c0) - SW'(r);
  assign c1_sub   = SW'(c1) - SW'(r);
  assign c2_sub   = SW'(c2) - SW'(r);
  assign y_sum    = SW'(in_q.measured_angle) - SW'(angle);
  assign bias_sum = SW'(bias) + SW'(r);

  // Divider operands: magnitudes, the sign is applied after the quotient.
  assign dp = (cmd.op == OP_DIV1) ? c2 : c0;
  assign pa = dp[31] ? (33'd0 - {dp[31], dp}) : {dp[31], dp};
  assign sa = s[DEN_W-1] ? (DEN_W'(0) - s) : s;

  abk_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.div_start),
    .p_mag (pa[31:0]),
    .s_mag (sa[32:0]),
    .done  (div_done),
    .q     (div_q),
    .ovf   (div_ovf)
  );

  assign qm   = (div_ovf || (div_q[QW-1] && (|div_q[QW-2:0]))) ? 34'h1_0000_0000
                                                               : {1'b0, div_q};
  assign gv   = div_neg ? -$signed({2'b00, qm}) : $signed({2'b00, qm});
  assign gsum = SW'(gv);

  assign stat.s_zero   = (s == '0);
  assign stat.div_done = div_done;

  always_ff @(posedge clk) begin
    prod <= ma * mb;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      apn   <= ANGLE_NOISE_RST;
      bpn   <= BIAS_NOISE_RST;
      mn    <= MEAS_NOISE_RST;
      angle <= '0;
      bias  <= '0;
      c0    <= ONE_P;
      c1    <= '0;
      c2    <= '0;
      c3    <= ONE_P;
      fault <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_idx_t'(cfg_index))
          CFG_ANGLE_NOISE: apn <= cfg_data;
          CFG_BIAS_NOISE:  bpn <= cfg_data;
          CFG_MEAS_NOISE:  mn  <= cfg_data;
          default: ;
        endcase
      end
      if (cmd.load) begin
        in_q  <= in_word;
        fault <= 1'b0;
      end
      case (cmd.op)
        OP_RATE: begin
          rate  <= sat32(rate_sum);
          fault <= fault | ovf32(rate_sum);
        end
        OP_M2: begin
          angle <= sat32(ang_sum);
          fault <= fault | ovf32(ang_sum);
        end
        OP_M3: d <= r[32:0];
        OP_M4: begin
          c3    <= sat32(c3_sum);
          c1    <= sat32(c1_d);
          c2    <= sat32(c2_d);
          t     <= MW'(SW'(d) - SW'(c1) - SW'(c2) + SW'($signed({1'b0, apn})));
          fault <= fault | ovf32(c3_sum) | ovf32(c1_d) | ovf32(c2_d);
        end
        OP_M6: begin
          c0    <= sat32(c0_sum);
          fault <= fault | ovf32(c0_sum);
        end
        OP_Y: begin
          y     <= sat32(y_sum);
          s     <= DEN_W'(c0) + DEN_W'($signed({1'b0, mn}));
          p00   <= c0;
          p01   <= c1;
          k0    <= '0;
          k1    <= '0;
          fault <= fault | ovf32(y_sum);
        end
        OP_DIV0, OP_DIV1: begin
          div_neg <= dp[31] ^ s[DEN_W-1];
          if (s == '0) begin
            fault <= 1'b1;
          end
        end
        OP_WAIT0: begin
          if (div_done) begin
            k0    <= sat32(gsum);
            fault <= fault | ovf32(gsum);
          end
        end
        OP_WAIT1: begin
          if (div_done) begin
            k1    <= sat32(gsum);
            fault <= fault | ovf32(gsum);
          end
        end
        OP_U2: begin
          angle <= sat32(ang_sum);
          fault <= fault | ovf32(ang_sum);
        end
        OP_U3: begin
          bias  <= sat32(bias_sum);
          fault <= fault | ovf32(bias_sum);
        end
        OP_U4: begin
          c0    <= sat32(c0_sub);
          fault <= fault | ovf32(c0_sub);
        end
        OP_U5: begin
          c1    <= sat32(c1_sub);
          fault <= fault | ovf32(c1_sub);
        end
        OP_U6: begin
          c2    <= sat32(c2_sub);
          fault <= fault | ovf32(c2_sub);
        end
        OP_U7: begin
          c3    <= sat32(c3_sub);
          fault <= fault | ovf32(c3_sub);
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_word.angle_estimate_out <= angle;
      out_word.bias_estimate_out  <= bias;
      out_word.unbiased_rate      <= rate;
      out_word.fault_flag         <= fault;
    end
  end

endmodule

>>> rtl/abk_ctrl.sv
`timescale 1ns / 1ps
module abk_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  output logic            out_valid,
  input  logic            out_ready,
  input  abk_pkg::stat_t  stat,
  output abk_pkg::cmd_t   cmd
);
  import abk_pkg::*;

  typedef enum logic [20:0] {
    ST_IDLE = 21'h000001,
    ST_RATE = 21'h000002,
    ST_M1   = 21'h000004,
    ST_M2   = 21'h000008,
    ST_M3   = 21'h000010,
    ST_M4   = 21'h000020,
    ST_M5   = 21'h000040,
    ST_M6   = 21'h000080,
    ST_Y    = 21'h000100,
    ST_D0S  = 21'h000200,
    ST_W0   = 21'h000400,
    ST_D1S  = 21'h000800,
    ST_W1   = 21'h001000,
    ST_U1   = 21'h002000,
    ST_U2   = 21'h004000,
    ST_U3   = 21'h008000,
    ST_U4   = 21'h010000,
    ST_U5   = 21'h020000,
    ST_U6   = 21'h040000,
    ST_U7   = 21'h080000,
    ST_DONE = 21'h100000
  } state_t;

  state_t state, state_next;

  assign in_ready = (state == ST_IDLE);

  always_comb begin
    state_next    = state;
    cmd.load      = 1'b0;
    cmd.out_load  = 1'b0;
    cmd.div_start = 1'b0;
    cmd.op        = OP_IDLE;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_RATE;
        end
      end
      ST_RATE: begin cmd.op = OP_RATE; state_next = ST_M1; end
      ST_M1:   begin cmd.op = OP_M1;   state_next = ST_M2; end
      ST_M2:   begin cmd.op = OP_M2;   state_next = ST_M3; end
      ST_M3:   begin cmd.op = OP_M3;   state_next = ST_M4; end
      ST_M4:   begin cmd.op = OP_M4;   state_next = ST_M5; end
      ST_M5:   begin cmd.op = OP_M5;   state_next = ST_M6; end
      ST_M6:   begin cmd.op = OP_M6;   state_next = ST_Y;  end
      ST_Y:    begin cmd.op = OP_Y;    state_next = ST_D0S; end
      ST_D0S: begin
        cmd.op = OP_DIV0;
        // A zero variance leaves both gains at zero.
        if (stat.s_zero) begin
          state_next = ST_U1;
        end else begin
          cmd.div_start = 1'b1;
          state_next    = ST_W0;
        end
      end
      ST_W0: begin
        cmd.op = OP_WAIT0;
        if (stat.div_done) begin
          state_next = ST_D1S;
        end
      end
      ST_D1S: begin
        cmd.op        = OP_DIV1;
        cmd.div_start = 1'b1;
        state_next    = ST_W1;
      end
      ST_W1: begin
        cmd.op = OP_WAIT1;
        if (stat.div_done) begin
          state_next = ST_U1;
        end
      end
      ST_U1: begin cmd.op = OP_U1; state_next = ST_U2; end
      ST_U2: begin cmd.op = OP_U2; state_next = ST_U3; end
      ST_U3: begin cmd.op = OP_U3; state_next = ST_U4; end
      ST_U4: begin cmd.op = OP_U4; state_next = ST_U5; end
      ST_U5: begin cmd.op = OP_U5; state_next = ST_U6; end
      ST_U6: begin cmd.op = OP_U6; state_next = ST_U7; end
      ST_U7: begin cmd.op = OP_U7; state_next = ST_DONE; end
      ST_DONE: begin
        cmd.op = OP_DONE;
        if (!out_valid || out_ready) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

`ifndef ASSERT_OFF
  a_load_starts: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> (state == ST_RATE))
    else $error("accepted word did not start the sequence");
  a_done_in_wait: assert property (@(posedge clk) disable iff (rst)
    stat.div_done |-> (state == ST_W0 || state == ST_W1))
    else $error("divider finished outside a wait state");
  a_out_loaded: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |=> (out_valid && state == ST_IDLE))
    else $error("result load did not raise valid");
`endif

endmodule

>>> test/kalman_checker.sv
`timescale 1ns / 1ps
// Watches both channels and the register port, predicts each output word from
// its own copy of the filter state, and compares field by field.
module kalman_checker
  import abk_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_ready,
  input  in_word_t    in_data,
  input  logic        out_valid,
  input  logic        out_ready,
  input  out_word_t   out_data,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [30:0] cfg_data,
  output int          errors,
  output int          pending
);

  longint est_angle, est_bias;
  longint cov [4];
  longint q_angle, q_bias, r_meas;
  bit     sat_hit;
  out_word_t expected_words[$];

  function automatic longint clamp32(longint v);
    if (v > 64'sd2147483647) begin
      sat_hit = 1;
      return 64'sd2147483647;
    end
    if (v < -64'sd2147483648) begin
      sat_hit = 1;
      return -64'sd2147483648;
    end
    return v;
  endfunction

  // Drops 24 fraction bits, rounding half away from zero.
  function automatic longint drop_frac(longint v);
    longint m;
    m = (v < 0) ? -v : v;
    m = (m + (64'sd1 <<< 23)) >>> 24;
    return (v < 0) ? -m : m;
  endfunction

  function automatic longint kalman_gain(longint p, longint s);
    bit      neg;
    longint  n, d, q;
    neg = (p < 0) != (s < 0);
    n = (p < 0) ? -p : p;
    d = (s < 0) ? -s : s;
    n = n <<< 24;
    q = (2 * n + d) / (2 * d);
    if (q > 64'sh1_0000_0000) q = 64'sh1_0000_0000;
    return clamp32(neg ? -q : q);
  endfunction

  function automatic out_word_t filter_step(in_word_t w);
    longint meas, gyro, dt, rate, d, t, y, s, k0, k1, p00, p01;
    out_word_t r;
    meas = longint'(w.measured_angle);
    gyro = longint'(w.measured_rate);
    dt = longint'({40'd0, w.time_step});
    k0 = 0;
    k1 = 0;
    sat_hit = 0;
    rate = clamp32(gyro - est_bias);
    est_angle = clamp32(est_angle + drop_frac(dt * rate));
    d = drop_frac(dt * cov[3]);
    t = d - cov[1] - cov[2] + q_angle;
    cov[0] = clamp32(cov[0] + drop_frac(dt * t));
    cov[1] = clamp32(cov[1] - d);
    cov[2] = clamp32(cov[2] - d);
    cov[3] = clamp32(cov[3] + drop_frac(q_bias * dt));
    y = clamp32(meas - est_angle);
    s = cov[0] + r_meas;
    if (s == 0) begin
      sat_hit = 1;
    end else begin
      k0 = kalman_gain(cov[0], s);
      k1 = kalman_gain(cov[2], s);
    end
    est_angle = clamp32(est_angle + drop_frac(k0 * y));
    est_bias = clamp32(est_bias + drop_frac(k1 * y));
    p00 = cov[0];
    p01 = cov[1];
    cov[0] = clamp32(cov[0] - drop_frac(k0 * p00));
    cov[1] = clamp32(cov[1] - drop_frac(k0 * p01));
    cov[2] = clamp32(cov[2] - drop_frac(k1 * p00));
    cov[3] = clamp32(cov[3] - drop_frac(k1 * p01));
    r.angle_estimate_out = est_angle[31:0];
    r.bias_estimate_out = est_bias[31:0];
    r.unbiased_rate = rate[31:0];
    r.fault_flag = sat_hit;
    return r;
  endfunction

  assign pending = expected_words.size();

  always @(posedge clk) begin
    out_word_t exp_w;
    if (rst) begin
      est_angle = 0;
      est_bias = 0;
      cov = '{64'sd16777216, 0, 0, 64'sd16777216};
      q_angle = longint'(ANGLE_NOISE_RST);
      q_bias = longint'(BIAS_NOISE_RST);
      r_meas = longint'(MEAS_NOISE_RST);
      expected_words.delete();
      errors <= 0;
    end else begin
      if (cfg_we) begin
        case (cfg_idx_t'(cfg_index))
          CFG_ANGLE_NOISE: q_angle = longint'(cfg_data);
          CFG_BIAS_NOISE:  q_bias = longint'(cfg_data);
          CFG_MEAS_NOISE:  r_meas = longint'(cfg_data);
          default: ;
        endcase
      end
      if (in_valid && in_ready) expected_words.push_back(filter_step(in_data));
      if (out_valid && out_ready) begin
        if (expected_words.size() == 0) begin
          if (errors < 10) $display("ERROR: output word with nothing expected: %h", out_data);
          errors <= errors + 1;
        end else begin
          exp_w = expected_words.pop_front();
          if (exp_w !== out_data) begin
            if (errors < 10)
              $display("ERROR: word mismatch exp a=%h b=%h r=%h f=%b got a=%h b=%h r=%h f=%b",
                       exp_w.angle_estimate_out, exp_w.bias_estimate_out, exp_w.unbiased_rate,
                       exp_w.fault_flag, out_data.angle_estimate_out,
                       out_data.bias_estimate_out, out_data.unbiased_rate,
                       out_data.fault_flag);
            errors <= errors + 1;
          end
        end
      end
    end
  end

endmodule

>>> test/tb.sv
`timescale 1ns / 1ps
// Testbench for the angle and gyro-bias Kalman filter. A directed run covers
// the reset defaults, field extremes, zero and negative innovation variance
// and saturation; random phases then sweep the noise registers with mostly
// realistic sensor words plus some full-range noise. The checker predicts
// every output word and the top only drives stimulus and reports the verdict.
module tb;
  import abk_pkg::*;

  logic clk;
  logic rst;
  logic cfg_we;
  logic [1:0] cfg_index;
  logic [CFG_W-1:0] cfg_data;
  int errors;
  int pending;
  int send_idle_pct;
  int recv_idle_pct;

  abk_in_if in_ch ();
  abk_out_if out_ch ();

  angle_bias_kalman_filter dut (
    .clk(clk), .rst(rst), .in_ch(in_ch.sink), .out_ch(out_ch.source),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  kalman_checker chk (
    .clk(clk), .rst(rst),
    .in_valid(in_ch.valid), .in_ready(in_ch.ready), .in_data(in_ch.data),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_data(out_ch.data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .errors(errors), .pending(pending)
  );

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  // The receiver stalls at random at the rate of the current phase.
  always @(posedge clk) begin
    if (rst) out_ch.ready <= 1'b0;
    else out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Sends one word, with an optional idle gap first; returns at the edge that
  // accepts it. Valid stays up until the next word or an idle cycle.
  task automatic send_word(input logic [31:0] angle, input logic [31:0] rate,
                           input logic [23:0] dt);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data <= '{angle, rate, dt};
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  // Registers may only change while nothing is in flight, so wait until
  // every accepted word has come back, then a little longer.
  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (120) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [CFG_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Mostly realistic samples: angles within about +/-0.18, modest
  // rates and millisecond steps, with occasional full-range words.
  task automatic random_word();
    logic [31:0] a, r;
    logic [23:0] dt;
    if ($urandom_range(9) == 0) begin
      a = $urandom;
      r = $urandom;
      dt = 24'($urandom);
    end else begin
      a = 32'($signed($urandom_range(6000000)) - 3000000);
      r = 32'($signed($urandom_range(20000000)) - 10000000);
      dt = 24'($urandom_range(40000));
    end
    send_word(a, r, dt);
  endtask

  initial begin
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = CFG_ANGLE_NOISE;
    cfg_data = '0;
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    send_idle_pct = 6;
    recv_idle_pct = 58;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed words under the reset noise values.
    send_word(32'h0000_0000, 32'h0000_0000, 24'd0);
    send_word(32'h7FFF_FFFF, 32'h7FFF_FFFF, 24'hFF_FFFF);
    send_word(32'h8000_0000, 32'h8000_0000, 24'hFF_FFFF);
    send_word(32'h8000_0000, 32'h7FFF_FFFF, 24'h00_0001);
    send_word(32'h7FFF_FFFF, 32'h8000_0000, 24'h80_0000);
    send_word(32'h0001_0000, 32'h0000_8000, 24'd16777);
    send_word(32'hFFFF_0000, 32'hFFFF_8000, 24'd16777);
    // The sender holds off until every word has come back.
    drain();

    // Zero innovation variance: R zero and no time step, so the variance rests on P00 alone.
    write_reg(CFG_MEAS_NOISE, '0);
    write_reg(CFG_ANGLE_NOISE, '0);
    write_reg(CFG_BIAS_NOISE, '0);
    @(posedge clk);
    rst <= 1'b0;
    send_word(32'h0002_0000, 32'h0001_0000, 24'd0);
    send_word(32'h0002_0000, 32'h0001_0000, 24'd0);
    send_word(32'h0002_0000, 32'h0001_0000, 24'd1000);
    drain();

    // Largest noise terms drive the covariance into saturation, after which
    // the innovation variance can go negative.
    write_reg(CFG_MEAS_NOISE, 31'h7FFF_FFFF);
    write_reg(CFG_ANGLE_NOISE, 31'h7FFF_FFFF);
    write_reg(CFG_BIAS_NOISE, 31'h7FFF_FFFF);
    repeat (8) send_word($urandom, $urandom, 24'hFF_FFFF);
    drain();

    // Random phases, each with new noise values, cycling the idle pattern.
    for (int ph = 0; ph < 9; ph++) begin
      if (ph == 3) begin
        send_idle_pct = 58;
        recv_idle_pct = 6;
      end else if (ph == 6) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      write_reg(CFG_ANGLE_NOISE, (ph % 4 == 0) ? 31'd0 : 31'($urandom_range(200000)));
      write_reg(CFG_BIAS_NOISE, (ph % 4 == 1) ? 31'h7FFF_FFFF : 31'($urandom_range(400000)));
      write_reg(CFG_MEAS_NOISE, (ph % 4 == 2) ? 31'd0 : 31'($urandom));
      repeat (70) random_word();
      drain();
    end

    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
